>>> rtl/lpht_pkg.sv
// shared types and constants for the linear probing hash table core
// command and status codes, fnv-1 step, controller state encoding
// no dependencies
package lpht_pkg;

    // field widths of the stream beats
    localparam int KEY_W       = 64;
    localparam int LEN_W       = 4;
    localparam int VALUE_IN_W  = 32;
    localparam int SLOT_W      = 12;
    localparam int IN_TDATA_W  = 104;
    localparam int OUT_TDATA_W = 48;

    // command codes
    localparam logic [1:0] CMD_GET           = 2'd0;
    localparam logic [1:0] CMD_INSERT        = 2'd1;
    localparam logic [1:0] CMD_GET_OR_INSERT = 2'd2;
    localparam logic [1:0] CMD_NONE          = 2'd3;

    // status codes
    localparam logic [1:0] ST_FOUND     = 2'd0;
    localparam logic [1:0] ST_INSERTED  = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    // fnv-1 64-bit offset basis
    localparam logic [63:0] FNV_OFFSET = 64'hcbf29ce484222325;

    // controller states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_MOD,
        S_CHECK
    } t_state;

    // one fnv-1 byte step: multiply by the prime (2^40 + 0x1b3), then xor the byte
    function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
        logic [63:0] p;
        p = h + (h << 1) + (h << 4) + (h << 5) + (h << 7) + (h << 8) + (h << 40);
        return p ^ {56'd0, b};
    endfunction

endpackage

>>> rtl/linear_probe_hash_table_core.sv
// linear probing hash table core: fnv-1 hash, probe walk through one slot ram
// steps: hashing of the key bytes (0..8 of them), a modulo by TABLE_SIZE unless it is a
// power of two, a probe walk through the slots in turn, then the output register
// one beat at a time: the next request is taken once the previous one is resolved
// reset: synchronous active low; a clearing pass writes every slot empty, during
// which no request beat is accepted
module linear_probe_hash_table_core #(
    parameter int TABLE_SIZE    = 4096,
    parameter int MAX_KEY_BYTES = 8,
    parameter int VALUE_WIDTH   = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // key_bytes[63:0], key_len[67:64], value_in[99:68], zero fill
    input  logic [lpht_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // cmd[1:0]
    input  logic [1:0]                        s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // value_out[31:0], slot[43:32], zero fill
    output logic [lpht_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    // status[1:0]
    output logic [1:0]                        m_axis_tuser
);

    import lpht_pkg::*;

    localparam int AW         = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
    localparam bit IS_POW2    = (TABLE_SIZE & (TABLE_SIZE - 1)) == 0;
    localparam int KW         = 8 * MAX_KEY_BYTES;
    localparam int SVW        = (VALUE_WIDTH < VALUE_IN_W) ? VALUE_WIDTH : VALUE_IN_W;
    localparam int EW         = 1 + LEN_W + KW + SVW;
    localparam int MOD_BITS   = 4;
    localparam int MOD_CYCLES = KEY_W / MOD_BITS;

    localparam logic [AW-1:0]    LAST_IDX = AW'(TABLE_SIZE - 1);
    localparam logic [AW:0]      TS_EXT   = (AW + 1)'(TABLE_SIZE);
    localparam logic [LEN_W-1:0] MKB_L    = LEN_W'(MAX_KEY_BYTES);
    localparam logic [3:0]       MOD_LAST = 4'(MOD_CYCLES - 1);

    // control registers
    t_state           r_state, n_state;
    logic [AW-1:0]    r_clr_addr, n_clr_addr;
    logic             r_o_valid, n_o_valid;

    // request payload and working registers
    logic [1:0]       r_cmd, n_cmd;
    logic [KEY_W-1:0] r_key, n_key;
    logic [KEY_W-1:0] r_kshift, n_kshift;
    logic [LEN_W-1:0] r_len, n_len;
    logic [SVW-1:0]   r_val, n_val;
    logic [3:0]       r_bcnt, n_bcnt;
    logic [63:0]      r_hash, n_hash;
    logic [AW-1:0]    r_rem, n_rem;
    logic [3:0]       r_mcnt, n_mcnt;
    logic [AW-1:0]    r_idx, n_idx;
    logic [AW-1:0]    r_pcnt, n_pcnt;

    // result registers
    logic [1:0]       r_o_status, n_o_status;
    logic [31:0]      r_o_value, n_o_value;
    logic [SLOT_W-1:0] r_o_slot, n_o_slot;

    // slot ram signals
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [EW-1:0]    ram_wdata;
    logic [EW-1:0]    ram_rdata;

    // input beat fields
    logic [KEY_W-1:0] in_key;
    logic [LEN_W-1:0] in_len;
    logic [SVW-1:0]   in_val;
    logic [LEN_W-1:0] in_lim;
    logic [LEN_W-1:0] in_eff;
    logic [KEY_W-1:0] in_key_m;
    logic             in_go;
    logic             in_acc;

    // datapath helpers
    logic [63:0]      w_hash_next;
    logic             w_hash_last;
    logic [AW:0]      w_rem_t;
    logic [AW-1:0]    w_rem_next;

    // probe decision
    logic             rd_valid;
    logic [LEN_W-1:0] rd_len;
    logic [KW-1:0]    rd_key;
    logic [SVW-1:0]   rd_val;
    logic             rd_match;
    logic             out_free;
    logic             w_res;
    logic             w_res_write;
    logic [1:0]       w_res_status;
    logic [31:0]      w_res_value;

    // slot table: {valid, key length, key, data}
    lpht_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_SIZE)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (n_idx),
        .o_rdata (ram_rdata)
    );

    // request decode: length bounded by the limit and by the first zero byte
    always_comb begin
        in_key = s_axis_tdata[KEY_W-1:0];
        in_len = s_axis_tdata[KEY_W +: LEN_W];
        in_val = s_axis_tdata[KEY_W + LEN_W +: SVW];
        in_lim = (in_len > MKB_L) ? MKB_L : in_len;
        in_eff = '0;
        in_go  = 1'b1;
        for (int i = 0; i < 8; i++) begin
            if (in_go && (LEN_W'(i) < in_lim) && (in_key[8*i +: 8] != 8'd0)) begin
                in_eff = LEN_W'(i + 1);
            end else begin
                in_go = 1'b0;
            end
        end
        for (int i = 0; i < 8; i++) begin
            in_key_m[8*i +: 8] = (LEN_W'(i) < in_eff) ? in_key[8*i +: 8] : 8'd0;
        end
    end

    assign in_acc = s_axis_tvalid && (r_state == S_IDLE);

    // one hash byte per cycle
    assign w_hash_next = fnv_step(r_hash, r_kshift[7:0]);
    assign w_hash_last = (r_bcnt + 4'd1) == r_len;

    // modulo by table size, four restoring steps per cycle from the top bit down
    always_comb begin
        w_rem_t = {1'b0, r_rem};
        for (int j = 0; j < MOD_BITS; j++) begin
            w_rem_t = {w_rem_t[AW-1:0], r_hash[KEY_W-1-j]};
            if (w_rem_t >= TS_EXT) begin
                w_rem_t = w_rem_t - TS_EXT;
            end
        end
        w_rem_next = w_rem_t[AW-1:0];
    end

    // slot read fields and key compare
    assign rd_valid = ram_rdata[EW-1];
    assign rd_len   = ram_rdata[EW-2 -: LEN_W];
    assign rd_key   = ram_rdata[SVW +: KW];
    assign rd_val   = ram_rdata[SVW-1:0];
    assign rd_match = (rd_len == r_len) && (rd_key == r_key[KW-1:0]);
    assign out_free = !r_o_valid || m_axis_tready;

    // probe decision on the slot just read
    always_comb begin
        w_res        = 1'b1;
        w_res_write  = 1'b0;
        w_res_status = ST_NOT_FOUND;
        w_res_value  = '0;
        if (r_cmd == CMD_NONE) begin
            w_res_status = ST_NOT_FOUND;
        end else if (!rd_valid) begin
            if (r_cmd != CMD_GET) begin
                w_res_write  = 1'b1;
                w_res_status = ST_INSERTED;
                w_res_value  = 32'(r_val);
            end
        end else if (rd_match && (r_cmd != CMD_INSERT)) begin
            w_res_status = ST_FOUND;
            w_res_value  = 32'(rd_val);
        end else if (r_pcnt == LAST_IDX) begin
            w_res_status = (r_cmd == CMD_GET) ? ST_NOT_FOUND : ST_FULL;
        end else begin
            w_res = 1'b0;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == LAST_IDX) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    if (s_axis_tuser == CMD_NONE) begin
                        n_state = S_CHECK;
                    end else if (in_eff == '0) begin
                        n_state = IS_POW2 ? S_CHECK : S_MOD;
                    end else begin
                        n_state = S_HASH;
                    end
                end
            end
            S_HASH: begin
                if (w_hash_last) begin
                    n_state = IS_POW2 ? S_CHECK : S_MOD;
                end
            end
            S_MOD: begin
                if (r_mcnt == MOD_LAST) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (w_res && out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and ram control per state
    always_comb begin
        n_clr_addr = r_clr_addr;
        n_o_valid  = r_o_valid && !m_axis_tready;
        n_cmd      = r_cmd;
        n_key      = r_key;
        n_kshift   = r_kshift;
        n_len      = r_len;
        n_val      = r_val;
        n_bcnt     = r_bcnt;
        n_hash     = r_hash;
        n_rem      = r_rem;
        n_mcnt     = r_mcnt;
        n_idx      = r_idx;
        n_pcnt     = r_pcnt;
        n_o_status = r_o_status;
        n_o_value  = r_o_value;
        n_o_slot   = r_o_slot;
        ram_we     = 1'b0;
        ram_waddr  = r_idx;
        ram_wdata  = {1'b1, r_len, r_key[KW-1:0], r_val};
        s_axis_tready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                ram_we     = 1'b1;
                ram_waddr  = r_clr_addr;
                ram_wdata  = '0;
                n_clr_addr = r_clr_addr + 1'b1;
            end
            S_IDLE: begin
                s_axis_tready = 1'b1;
                if (in_acc) begin
                    n_cmd    = s_axis_tuser;
                    n_key    = in_key_m;
                    n_kshift = in_key_m;
                    n_len    = in_eff;
                    n_val    = in_val;
                    n_bcnt   = '0;
                    n_hash   = FNV_OFFSET;
                    n_rem    = '0;
                    n_mcnt   = '0;
                    n_pcnt   = '0;
                    n_idx    = FNV_OFFSET[AW-1:0];
                end
            end
            S_HASH: begin
                n_hash   = w_hash_next;
                n_kshift = r_kshift >> 8;
                n_bcnt   = r_bcnt + 4'd1;
                n_idx    = w_hash_next[AW-1:0];
            end
            S_MOD: begin
                n_rem  = w_rem_next;
                n_hash = r_hash << MOD_BITS;
                n_mcnt = r_mcnt + 4'd1;
                n_idx  = w_rem_next;
            end
            S_CHECK: begin
                if (w_res) begin
                    if (out_free) begin
                        ram_we     = w_res_write;
                        n_o_valid  = 1'b1;
                        n_o_status = w_res_status;
                        n_o_value  = w_res_value;
                        n_o_slot   = ((w_res_status == ST_FOUND) ||
                                      (w_res_status == ST_INSERTED)) ? SLOT_W'(r_idx) : '0;
                    end
                end else begin
                    n_idx  = (r_idx == LAST_IDX) ? '0 : r_idx + 1'b1;
                    n_pcnt = r_pcnt + 1'b1;
                end
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_o_valid  <= n_o_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_key      <= n_key;
        r_kshift   <= n_kshift;
        r_len      <= n_len;
        r_val      <= n_val;
        r_bcnt     <= n_bcnt;
        r_hash     <= n_hash;
        r_rem      <= n_rem;
        r_mcnt     <= n_mcnt;
        r_idx      <= n_idx;
        r_pcnt     <= n_pcnt;
        r_o_status <= n_o_status;
        r_o_value  <= n_o_value;
        r_o_slot   <= n_o_slot;
    end

    // result beat
    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tuser  = r_o_status;
    assign m_axis_tdata  = {{(OUT_TDATA_W - 32 - SLOT_W){1'b0}}, r_o_slot, r_o_value};

endmodule

>>> rtl/lpht_ram.sv
// generic simple dual port ram, one write and one registered read per cycle
// used for the slot table of the hash table core
// no dependencies
module lpht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule
